// ===== rtl/hrc_pkg.sv =====
// Shared types, constants and ring helpers for the history ring with cursor.
// Used by hrc_store, history_ring_with_cursor_core and the bench; depends on nothing else.
`default_nettype none

package hrc_pkg;

    // Ring geometry.
    localparam int CAPACITY = 32;
    localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int SUM_W    = COUNT_W + 1;

    // Operation codes of an input transaction.
    typedef enum logic [2:0] {
        KIND_ADD     = 3'd0,
        KIND_FORWARD = 3'd1,
        KIND_BACK    = 3'd2,
        KIND_VIEW    = 3'd3,
        KIND_CLEAR   = 3'd4
    } kind_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EDGE  = 2'd1,
        STATUS_EMPTY = 2'd2
    } status_t;

    // One stored record.
    typedef struct packed {
        logic [31:0] id;
        logic [7:0]  source;
        logic [15:0] text;
        logic [31:0] stamp;
    } hrc_entry_t;

    // Write request from the pointer logic to the record store.
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } hrc_wr_t;

    // Reduce a sum below twice the capacity back into the ring.
    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] r;
        begin
            r = (s >= SUM_W'(CAPACITY)) ? (s - SUM_W'(CAPACITY)) : s;
            return r[SLOT_W-1:0];
        end
    endfunction

    // Next slot around the ring.
    function automatic logic [SLOT_W-1:0] ring_next(input logic [SLOT_W-1:0] s);
        begin
            return wrap_slot(SUM_W'(s) + SUM_W'(1));
        end
    endfunction

    // Previous slot around the ring.
    function automatic logic [SLOT_W-1:0] ring_prev(input logic [SLOT_W-1:0] s);
        begin
            return wrap_slot(SUM_W'(s) + SUM_W'(CAPACITY - 1));
        end
    endfunction

endpackage

`default_nettype wire

// ===== rtl/history_ring_with_cursor_core.sv =====
// Top level of the history ring with cursor: pointer update and result path.
// Depends on hrc_pkg and instantiates hrc_store.
//
// Usage:
//   A command transaction is taken at a rising edge where start is high and
//   busy is low. kind selects add, forward, back, view or clear; the record
//   fields matter only for add. busy stays low, so a command may be issued
//   in every cycle.
//   Each command yields one result, shown for exactly one cycle with done
//   high, in the cycle right after the command was taken (throughput one
//   command per cycle). The result is registered and comes
//   from the registered read port of the record store, which is addressed
//   with the updated cursor while the pointer registers settle; an add to
//   the slot under the cursor is forwarded into that read.
//   The result carries status, the record under the cursor (zero when the
//   store is empty), the record count and the cursor offset from the
//   oldest record.
//   Reset empties the store at once: the pointers and the count clear, and
//   the record memory itself is not swept. The receiver cannot stall;
//   results must be taken in the cycle that they appear.
`default_nettype none

module history_ring_with_cursor_core
    import hrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] record_id,
    input  wire logic [7:0]  source_tag,
    input  wire logic [15:0] text_tag,
    input  wire logic [31:0] time_stamp,
    output logic             done,
    output logic [1:0]       status,
    output logic [31:0]      cur_id,
    output logic [7:0]       cur_source,
    output logic [15:0]      cur_text,
    output logic [31:0]      cur_time,
    output logic [5:0]       entry_count,
    output logic [4:0]       cursor_offset
);

    logic [SLOT_W-1:0]  oldest_reg,  oldest_next;
    logic [COUNT_W-1:0] held_reg,    held_next;
    logic [SLOT_W-1:0]  cursor_reg,  cursor_next;
    status_t            status_reg,  status_next;
    logic               done_reg;

    logic               accept;
    hrc_wr_t            wr;
    hrc_entry_t         wr_data;
    hrc_entry_t         rd_data;

    // Intermediate values of an add.
    logic               full;
    logic [SLOT_W-1:0]  add_oldest;
    logic [COUNT_W-1:0] add_held;
    logic [SLOT_W-1:0]  add_cursor;
    logic [SLOT_W-1:0]  add_slot;
    logic [SLOT_W-1:0]  newest;
    logic [SLOT_W-1:0]  offset;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Record presented for an add.
    assign wr_data.id     = record_id;
    assign wr_data.source = source_tag;
    assign wr_data.text   = text_tag;
    assign wr_data.stamp  = time_stamp;

    // Add: drop the oldest when full, then append after the newest.
    always_comb
    begin
        full       = (held_reg == COUNT_W'(CAPACITY));
        add_oldest = oldest_reg;
        add_held   = held_reg;
        add_cursor = cursor_reg;
        if (full)
        begin
            add_oldest = ring_next(oldest_reg);
            add_held   = COUNT_W'(CAPACITY - 1);
            if (cursor_reg == oldest_reg)
            begin
                add_cursor = add_oldest;
            end
        end
        add_slot = wrap_slot(SUM_W'(add_oldest) + SUM_W'(add_held));
        if (add_held == '0)
        begin
            add_cursor = add_slot;
        end
        // Only meaningful while the store holds at least one record.
        newest = wrap_slot(SUM_W'(oldest_reg) + SUM_W'(held_reg) - SUM_W'(1));
    end

    // Next pointer state, status and store write for the command.
    always_comb
    begin
        oldest_next = oldest_reg;
        held_next   = held_reg;
        cursor_next = cursor_reg;
        status_next = STATUS_OK;
        wr.en       = 1'b0;
        wr.addr     = add_slot;
        if (accept)
        begin
            case (kind)
                KIND_ADD:
                begin
                    oldest_next = add_oldest;
                    held_next   = add_held + COUNT_W'(1);
                    cursor_next = add_cursor;
                    wr.en       = 1'b1;
                end
                KIND_FORWARD:
                begin
                    if (held_reg != '0)
                    begin
                        if (cursor_reg != newest)
                        begin
                            cursor_next = ring_next(cursor_reg);
                        end
                        else
                        begin
                            status_next = STATUS_EDGE;
                        end
                    end
                end
                KIND_BACK:
                begin
                    if (held_reg != '0)
                    begin
                        if (cursor_reg != oldest_reg)
                        begin
                            cursor_next = ring_prev(cursor_reg);
                        end
                        else
                        begin
                            status_next = STATUS_EDGE;
                        end
                    end
                end
                KIND_CLEAR:
                begin
                    oldest_next = '0;
                    held_next   = '0;
                    cursor_next = '0;
                end
                default:
                begin
                    // View and unused codes leave the state as it is.
                end
            endcase
            if (held_next == '0)
            begin
                status_next = STATUS_EMPTY;
            end
        end
    end

    // Pointer and result control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_reg <= '0;
            held_reg   <= '0;
            cursor_reg <= '0;
            status_reg <= STATUS_OK;
            done_reg   <= 1'b0;
        end
        else
        begin
            oldest_reg <= oldest_next;
            held_reg   <= held_next;
            cursor_reg <= cursor_next;
            if (accept)
            begin
                status_reg <= status_next;
            end
            done_reg <= accept;
        end
    end

    // Record memory, read at the updated cursor.
    hrc_store u_store
    (
        .clk     (clk),
        .wr      (wr),
        .wr_data (wr_data),
        .rd_addr (cursor_next),
        .rd_data (rd_data)
    );

    // Cursor position measured from the oldest record.
    always_comb
    begin
        if (cursor_reg >= oldest_reg)
        begin
            offset = cursor_reg - oldest_reg;
        end
        else
        begin
            offset = wrap_slot(SUM_W'(cursor_reg) + SUM_W'(CAPACITY) - SUM_W'(oldest_reg));
        end
    end

    // Result ports; an empty store reports zeros.
    always_comb
    begin
        done          = done_reg;
        status        = status_reg;
        entry_count   = 6'(held_reg);
        if (held_reg == '0)
        begin
            cur_id        = '0;
            cur_source    = '0;
            cur_text      = '0;
            cur_time      = '0;
            cursor_offset = '0;
        end
        else
        begin
            cur_id        = rd_data.id;
            cur_source    = rd_data.source;
            cur_text      = rd_data.text;
            cur_time      = rd_data.stamp;
            cursor_offset = 5'(offset);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hrc_store.sv =====
// Record store of the history ring: one write port and one registered read port.
// Depends on hrc_pkg for the entry type and ring geometry.
`default_nettype none

module hrc_store
    import hrc_pkg::*;
(
    input  wire logic              clk,
    input  wire hrc_wr_t           wr,
    input  wire hrc_entry_t        wr_data,
    input  wire logic [SLOT_W-1:0] rd_addr,
    output hrc_entry_t             rd_data
);

    hrc_entry_t mem [CAPACITY];
    hrc_entry_t rd_data_reg;

    // Write the appended record.
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr_data;
        end
    end

    // Registered read; a write to the same slot in the same cycle is forwarded.
    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== bench/history_ring_with_cursor_checker.sv =====
// Checker for the history ring with cursor: predicts every result and compares it.
// Depends on hrc_pkg; instantiated next to the block by history_ring_with_cursor_core_test.
`default_nettype none

module history_ring_with_cursor_checker
    import hrc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic        busy,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] record_id,
    input  wire logic [7:0]  source_tag,
    input  wire logic [15:0] text_tag,
    input  wire logic [31:0] time_stamp,
    input  wire logic        done,
    input  wire logic [1:0]  status,
    input  wire logic [31:0] cur_id,
    input  wire logic [7:0]  cur_source,
    input  wire logic [15:0] cur_text,
    input  wire logic [31:0] cur_time,
    input  wire logic [5:0]  entry_count,
    input  wire logic [4:0]  cursor_offset,
    output int               fail_count,
    output int               pending
);

    // What the block should show for one command transaction.
    typedef struct {
        status_t     status;
        hrc_entry_t  entry;
        logic [5:0]  count;
        logic [4:0]  offset;
    } cursor_view_t;

    // Shadow copy of the history ring.
    hrc_entry_t   history[CAPACITY];
    int           oldest_pos;
    int           held;
    int           cursor_pos;

    cursor_view_t expected_views[$];
    cursor_view_t want;
    int           errors_seen = 0;
    int           waiting = 0;

    assign fail_count = errors_seen;
    assign pending    = waiting;

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        begin
            $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, exp_val,
                     $realtime);
            errors_seen++;
        end
    endtask

    // Apply one command to the shadow ring and return the view it leaves.
    function automatic cursor_view_t browse_history(input logic [2:0] op,
                                                    input hrc_entry_t rec);
        cursor_view_t view;
        status_t      st;
        int           slot;
        logic         on_oldest;
        begin
            st = STATUS_OK;
            case (op)
                KIND_ADD:
                begin
                    if (held >= CAPACITY)
                    begin
                        // Full: drop the oldest record; a cursor on it follows.
                        on_oldest  = (cursor_pos == oldest_pos);
                        oldest_pos = (oldest_pos + 1) % CAPACITY;
                        held       = CAPACITY - 1;
                        if (on_oldest)
                            cursor_pos = oldest_pos;
                    end
                    slot = (oldest_pos + held) % CAPACITY;
                    history[slot] = rec;
                    if (held == 0)
                        cursor_pos = slot;
                    held++;
                end
                KIND_FORWARD:
                begin
                    if (held != 0)
                    begin
                        if (cursor_pos != (oldest_pos + held - 1) % CAPACITY)
                            cursor_pos = (cursor_pos + 1) % CAPACITY;
                        else
                            st = STATUS_EDGE;
                    end
                end
                KIND_BACK:
                begin
                    if (held != 0)
                    begin
                        if (cursor_pos != oldest_pos)
                            cursor_pos = (cursor_pos + CAPACITY - 1) % CAPACITY;
                        else
                            st = STATUS_EDGE;
                    end
                end
                KIND_CLEAR:
                begin
                    held       = 0;
                    oldest_pos = 0;
                    cursor_pos = 0;
                end
                default:
                begin
                    // View and the spare codes change nothing.
                end
            endcase

            if (held == 0)
            begin
                view.status = STATUS_EMPTY;
                view.entry  = '0;
                view.count  = '0;
                view.offset = '0;
            end
            else
            begin
                view.status = st;
                view.entry  = history[cursor_pos];
                view.count  = 6'(held);
                view.offset = 5'((cursor_pos + CAPACITY - oldest_pos) % CAPACITY);
            end
            return view;
        end
    endfunction

    // Predict on each accepted command, then check any result in the same cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oldest_pos = 0;
            held       = 0;
            cursor_pos = 0;
            expected_views.delete();
            waiting    = 0;
        end
        else
        begin
            if (start && !busy)
                expected_views.push_back(browse_history(kind,
                    '{id: record_id, source: source_tag, text: text_tag, stamp: time_stamp}));

            if (done === 1'b1)
            begin
                if (expected_views.size() == 0)
                begin
                    report_mismatch("unexpected result", 32'(status), 32'(STATUS_EMPTY));
                end
                else
                begin
                    want = expected_views.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", 32'(status), 32'(want.status));
                    if (cur_id !== want.entry.id)
                        report_mismatch("cur_id", cur_id, want.entry.id);
                    if (cur_source !== want.entry.source)
                        report_mismatch("cur_source", 32'(cur_source), 32'(want.entry.source));
                    if (cur_text !== want.entry.text)
                        report_mismatch("cur_text", 32'(cur_text), 32'(want.entry.text));
                    if (cur_time !== want.entry.stamp)
                        report_mismatch("cur_time", cur_time, want.entry.stamp);
                    if (entry_count !== want.count)
                        report_mismatch("entry_count", 32'(entry_count), 32'(want.count));
                    if (cursor_offset !== want.offset)
                        report_mismatch("cursor_offset", 32'(cursor_offset), 32'(want.offset));
                end
            end
            else if (done !== 1'b0)
            begin
                report_mismatch("done unknown", 32'(done), 32'd0);
            end

            waiting = expected_views.size();
        end
    end

endmodule

`default_nettype wire

// ===== bench/history_ring_with_cursor_core_test.sv =====
// Testbench top for history_ring_with_cursor_core: clock, reset, command stimulus, verdict.
// Depends on hrc_pkg, the block itself and history_ring_with_cursor_checker.
`default_nettype none

module history_ring_with_cursor_core_test;
    import hrc_pkg::*;

    // Codes beyond the defined operations; the block must treat them as view.
    localparam logic [2:0] KIND_SPARE_A = 3'd5;
    localparam logic [2:0] KIND_SPARE_B = 3'd6;
    localparam logic [2:0] KIND_SPARE_C = 3'd7;

    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 75;
    localparam int RUN_LIMIT    = 200000;
    localparam int DRAIN_CYCLES = 4;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [2:0]  kind;
    logic [31:0] record_id;
    logic [7:0]  source_tag;
    logic [15:0] text_tag;
    logic [31:0] time_stamp;
    logic        done;
    logic [1:0]  status;
    logic [31:0] cur_id;
    logic [7:0]  cur_source;
    logic [15:0] cur_text;
    logic [31:0] cur_time;
    logic [5:0]  entry_count;
    logic [4:0]  cursor_offset;
    int          fail_count;
    int          pending;
    int          cycle_count = 0;
    int          idle_plan[3] = '{0, 73, 36};

    history_ring_with_cursor_core uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .record_id(record_id), .source_tag(source_tag), .text_tag(text_tag),
        .time_stamp(time_stamp), .done(done), .status(status), .cur_id(cur_id),
        .cur_source(cur_source), .cur_text(cur_text), .cur_time(cur_time),
        .entry_count(entry_count), .cursor_offset(cursor_offset)
    );

    history_ring_with_cursor_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .kind(kind),
        .record_id(record_id), .source_tag(source_tag), .text_tag(text_tag),
        .time_stamp(time_stamp), .done(done), .status(status), .cur_id(cur_id),
        .cur_source(cur_source), .cur_text(cur_text), .cur_time(cur_time),
        .entry_count(entry_count), .cursor_offset(cursor_offset),
        .fail_count(fail_count), .pending(pending)
    );

    // Clock with an 8 unit period; it starts low so the first rising edge
    // comes after reset is already asserted.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watchdog on the total run length.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Drive one command transaction from a falling edge until it is taken.
    task automatic issue_command(input logic [2:0] op, input logic [31:0] id,
                                 input logic [7:0] src, input logic [15:0] txt,
                                 input logic [31:0] stamp);
        begin
            start      <= 1'b1;
            kind       <= op;
            record_id  <= id;
            source_tag <= src;
            text_tag   <= txt;
            time_stamp <= stamp;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    // Hold the sender off until every expected result has come back.
    task automatic wait_until_drained();
        begin
            start <= 1'b0;
            @(negedge clk);
            while (pending != 0)
                @(negedge clk);
        end
    endtask

    initial
    begin
        int          idle_pct;
        int          tilt;
        int          roll;
        logic [2:0]  op;

        rst_n      = 1'b0;
        start      = 1'b0;
        kind       = KIND_VIEW;
        record_id  = '0;
        source_tag = '0;
        text_tag   = '0;
        time_stamp = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty store, single entry edges, field extremes, spare codes.
        issue_command(KIND_VIEW, '1, '1, '1, '1);
        issue_command(KIND_FORWARD, '0, '0, '0, '0);
        issue_command(KIND_BACK, '1, '1, '1, '1);
        issue_command(KIND_CLEAR, '0, '0, '0, '0);
        issue_command(KIND_SPARE_A, '1, '1, '1, '1);
        issue_command(KIND_ADD, '1, '1, '1, '1);
        issue_command(KIND_FORWARD, '0, '0, '0, '0);
        issue_command(KIND_BACK, '0, '0, '0, '0);
        issue_command(KIND_ADD, '0, '0, '0, '0);
        issue_command(KIND_VIEW, '0, '0, '0, '0);
        issue_command(KIND_FORWARD, '0, '0, '0, '0);
        issue_command(KIND_FORWARD, '0, '0, '0, '0);
        issue_command(KIND_ADD, 32'hA5A5_5A5A, 8'h5A, 16'hA55A, 32'h0F0F_F0F0);
        issue_command(KIND_BACK, '0, '0, '0, '0);
        issue_command(KIND_BACK, '0, '0, '0, '0);
        issue_command(KIND_BACK, '0, '0, '0, '0);
        issue_command(KIND_SPARE_B, '1, '1, '1, '1);
        issue_command(KIND_SPARE_C, '0, '0, '0, '0);
        issue_command(KIND_CLEAR, '1, '1, '1, '1);
        issue_command(KIND_VIEW, '0, '0, '0, '0);
        issue_command(KIND_ADD, 32'h8000_0001, 8'h80, 16'h8001, 32'h7FFF_FFFE);
        issue_command(KIND_CLEAR, '0, '0, '0, '0);
        wait_until_drained();

        // Random part: phases with different sender idling, each ending drained.
        for (int p = 0; p < PHASES; p++)
        begin
            idle_pct = idle_plan[p % 3];
            tilt = 0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // Every 25 commands lean toward filling, walking back or walking forward, or mix evenly.
                if (n % 25 == 0)
                    tilt = $urandom_range(3);
                roll = $urandom_range(99);
                if (roll < 1)
                    op = KIND_CLEAR;
                else if (roll < 3)
                    op = 3'($urandom_range(7, 5));
                else if (roll < 8)
                    op = KIND_VIEW;
                else
                begin
                    case (tilt)
                        0: op = (roll < 80) ? KIND_ADD
                              : ((roll < 90) ? KIND_FORWARD : KIND_BACK);
                        1: op = (roll < 20) ? KIND_ADD
                              : ((roll < 85) ? KIND_BACK : KIND_FORWARD);
                        2: op = (roll < 20) ? KIND_ADD
                              : ((roll < 85) ? KIND_FORWARD : KIND_BACK);
                        default: op = (roll < 50) ? KIND_ADD
                                    : ((roll < 75) ? KIND_FORWARD : KIND_BACK);
                    endcase
                end

                if (idle_pct != 0)
                begin
                    while ($urandom_range(99) < idle_pct)
                    begin
                        start <= 1'b0;
                        @(negedge clk);
                    end
                end

                issue_command(op, $urandom, 8'($urandom_range(255)),
                              16'($urandom_range(65535)), $urandom);
            end
            wait_until_drained();
        end

        // Let any late result show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/hrc_pkg.sv
rtl/hrc_store.sv
rtl/history_ring_with_cursor_core.sv
bench/history_ring_with_cursor_checker.sv
bench/history_ring_with_cursor_core_test.sv
